// File: sv/dts_pkg.sv
package dts_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges = 1024;
	localparam int VW = $clog2(MaxVertices);
	localparam int EW = $clog2(MaxEdges);
	localparam int EPW = EW + 1;
	localparam int DW = $clog2(MaxVertices + 1);
	localparam logic [EPW-1:0] NoEdge = EPW'(MaxEdges);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_TOP, ST_EDGE, ST_TGT, ST_EMIT, ST_EMITW, ST_CLEAR
	} dts_state_t;

	typedef struct packed {
		logic add_edge;
		logic run_init;
		logic scan_next;
		logic push_scan;
		logic read_top;
		logic follow_edge;
		logic visit_tgt;
		logic pop_top;
		logic set_cycle;
		logic emit;
		logic clear;
	} dts_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic scan_visited;
		logic stack_empty;
		logic top_done;
		logic tgt_skip;
		logic tgt_visited;
		logic tgt_on_stack;
		logic cycle;
		logic emit_done;
	} dts_status_t;
endpackage

// File: sv/dts_if.sv
interface dts_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [5:0] from_vertex;
	logic [5:0] to_vertex;
	modport source(output valid, kind, from_vertex, to_vertex, input ready);
	modport sink(input valid, kind, from_vertex, to_vertex, output ready);
endinterface

interface dts_out_if;
	logic valid;
	logic ready;
	logic [5:0] vertex;
	logic acyclic;
	logic last;
	modport source(output valid, vertex, acyclic, last, input ready);
	modport sink(input valid, vertex, acyclic, last, output ready);
endinterface

// File: sv/dts_datapath.sv
module dts_datapath (
	input logic clk,
	input logic arst_n,
	input dts_pkg::dts_cmd_t cmd,
	output dts_pkg::dts_status_t status,
	input logic [5:0] from_vertex,
	input logic [5:0] to_vertex,
	input logic [6:0] vertex_count,
	output logic [5:0] out_vertex,
	output logic out_acyclic,
	output logic out_last
);
	import dts_pkg::*;

	// edge store
	logic [EPW-1:0] first_q [MaxVertices];
	logic [MaxVertices-1:0] head_valid_q;
	logic [EW-1:0] tail_mem [MaxVertices];
	logic [EPW-1:0] next_mem [MaxEdges];
	logic [VW-1:0] tgt_mem [MaxEdges];
	logic [EPW-1:0] edges_q;
	logic link_pend_s1;
	logic [EW-1:0] link_addr_s1;
	logic [EPW-1:0] link_edge_s1;
	// search state
	logic [MaxVertices-1:0] visited_q, onstk_q;
	logic [VW-1:0] stk_v_mem [MaxVertices];
	logic [EPW-1:0] stk_c_mem [MaxVertices];
	logic [DW-1:0] depth_q;
	logic [VW-1:0] order_mem [MaxVertices];
	logic [DW-1:0] fill_q;
	logic [DW-1:0] emit_q;
	logic cycle_q;
	logic [DW-1:0] scan_q;
	logic [DW-1:0] n_q;
	logic [VW-1:0] top_v_q;
	logic [EPW-1:0] top_c_q;
	logic [EPW-1:0] nxt_q;
	logic [VW-1:0] w_q;
	logic [VW-1:0] ord_rd_q;
	logic [EPW-1:0] first_rd_q;
	logic fresh_q;

	logic [VW-1:0] top_idx;
	logic [VW-1:0] push_v;
	logic do_push;
	logic do_add;

	assign top_idx = VW'(depth_q - DW'(1));
	assign do_add = cmd.add_edge && edges_q < EPW'(MaxEdges);
	assign push_v = cmd.push_scan ? scan_q[VW-1:0] : w_q;
	assign do_push = cmd.push_scan || (cmd.visit_tgt && !visited_q[w_q]);

	always_ff @(posedge clk) begin
		if (do_add) begin
			tgt_mem[edges_q[EW-1:0]] <= to_vertex;
			next_mem[edges_q[EW-1:0]] <= NoEdge;
			tail_mem[from_vertex] <= edges_q[EW-1:0];
			if (!head_valid_q[from_vertex]) first_q[from_vertex] <= edges_q;
		end
		// old tail gets linked in the following cycle from a registered tail read
		if (link_pend_s1) next_mem[link_addr_s1] <= link_edge_s1;
		link_addr_s1 <= tail_mem[from_vertex];
		link_edge_s1 <= edges_q;
		if (do_push) stk_v_mem[depth_q[VW-1:0]] <= push_v;
		// cursor of a pushed vertex lands in the cycle after the push
		first_rd_q <= head_valid_q[push_v] ? first_q[push_v] : NoEdge;
		if (fresh_q) stk_c_mem[top_idx] <= first_rd_q;
		else if (cmd.follow_edge && top_c_q < NoEdge) stk_c_mem[top_idx] <= nxt_q;
		if (cmd.pop_top) order_mem[fill_q[VW-1:0]] <= top_v_q;
		top_v_q <= stk_v_mem[top_idx];
		top_c_q <= fresh_q ? first_rd_q : stk_c_mem[top_idx];
		nxt_q <= next_mem[top_c_q[EW-1:0]];
		w_q <= tgt_mem[top_c_q[EW-1:0]];
		ord_rd_q <= order_mem[VW'(fill_q - emit_q - DW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
			edges_q <= '0;
			link_pend_s1 <= 1'b0;
			fresh_q <= 1'b0;
			visited_q <= '0;
			onstk_q <= '0;
			depth_q <= '0;
			fill_q <= '0;
			emit_q <= '0;
			cycle_q <= 1'b0;
			scan_q <= '0;
			n_q <= DW'(1);
		end else begin
			link_pend_s1 <= do_add && head_valid_q[from_vertex];
			fresh_q <= do_push;
			if (do_add) begin
				edges_q <= edges_q + EPW'(1);
				if (!head_valid_q[from_vertex]) head_valid_q[from_vertex] <= 1'b1;
			end
			if (cmd.run_init) begin
				scan_q <= '0;
				depth_q <= '0;
				fill_q <= '0;
				emit_q <= '0;
				cycle_q <= 1'b0;
				visited_q <= '0;
				onstk_q <= '0;
				if (vertex_count == 7'd0) n_q <= DW'(1);
				else if (vertex_count > 7'(MaxVertices)) n_q <= DW'(MaxVertices);
				else n_q <= DW'(vertex_count);
			end
			if (cmd.scan_next) scan_q <= scan_q + DW'(1);
			if (do_push) begin
				visited_q[push_v] <= 1'b1;
				onstk_q[push_v] <= 1'b1;
				depth_q <= depth_q + DW'(1);
			end
			if (cmd.pop_top) begin
				onstk_q[top_v_q] <= 1'b0;
				fill_q <= fill_q + DW'(1);
				depth_q <= depth_q - DW'(1);
			end
			if (cmd.set_cycle) cycle_q <= 1'b1;
			if (cmd.emit) emit_q <= emit_q + DW'(1);
			if (cmd.clear) begin
				head_valid_q <= '0;
				edges_q <= '0;
				visited_q <= '0;
				onstk_q <= '0;
				depth_q <= '0;
				cycle_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.scan_done = scan_q >= n_q;
		status.scan_visited = visited_q[scan_q[VW-1:0]];
		status.stack_empty = depth_q == '0;
		status.top_done = top_c_q >= NoEdge;
		status.tgt_skip = {1'b0, w_q} >= n_q;
		status.tgt_visited = visited_q[w_q];
		status.tgt_on_stack = onstk_q[w_q];
		status.cycle = cycle_q || fill_q == '0;
		status.emit_done = emit_q + DW'(1) >= fill_q;
	end

	assign out_vertex = status.cycle ? '0 : ord_rd_q;
	assign out_acyclic = !status.cycle;
	assign out_last = status.cycle || status.emit_done;
endmodule

// File: sv/dts_ctrl.sv
module dts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_kind,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dts_pkg::dts_status_t status,
	output dts_pkg::dts_cmd_t cmd
);
	import dts_pkg::*;

	dts_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !in_kind) cmd.add_edge = 1'b1;
				if (in_valid && in_kind) begin
					cmd.run_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) state_d = ST_EMITW;
				else begin
					cmd.scan_next = 1'b1;
					if (!status.scan_visited) begin
						cmd.push_scan = 1'b1;
						state_d = ST_TOP;
					end
				end
			end
			ST_TOP: begin
				if (status.stack_empty) state_d = ST_SCAN;
				else state_d = ST_EDGE;
			end
			ST_EDGE: begin
				if (status.top_done) begin
					cmd.pop_top = 1'b1;
					state_d = ST_TOP;
				end else state_d = ST_TGT;
			end
			ST_TGT: begin
				cmd.follow_edge = 1'b1;
				state_d = ST_TOP;
				if (!status.tgt_skip) begin
					if (!status.tgt_visited) cmd.visit_tgt = 1'b1;
					else if (status.tgt_on_stack) begin
						cmd.set_cycle = 1'b1;
						state_d = ST_EMITW;
					end
				end
			end
			ST_EMITW: state_d = ST_EMIT;
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.emit = 1'b1;
					if (status.cycle || status.emit_done) state_d = ST_CLEAR;
					else state_d = ST_EMITW;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: sv/dfs_topological_sort.sv
// Edge words: one per cycle, no result.
// Run word: a depth-first search that starts a new root at each unvisited vertex,
// then a wait and an emit state per emitted vertex, and a clear state.
// One word in flight at a time; a run blocks input until its last result.
// arst_n clears the graph, marks and state; vertex_count resets to 1.
module dfs_topological_sort (
	input logic clk,
	input logic arst_n,
	dts_in_if.sink in_ch,
	dts_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import dts_pkg::*;

	logic [6:0] vertex_count_q;
	dts_cmd_t cmd;
	dts_status_t status;

	// single register at address 0
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {25'd0, vertex_count_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vertex_count_q <= 7'd1;
		else if (psel && penable && pwrite && paddr == 2'd0)
			vertex_count_q <= pwdata[6:0];
	end

	dts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd)
	);

	dts_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.from_vertex(in_ch.from_vertex), .to_vertex(in_ch.to_vertex),
		.vertex_count(vertex_count_q),
		.out_vertex(out_ch.vertex), .out_acyclic(out_ch.acyclic), .out_last(out_ch.last)
	);

	// a single run never pushes and pops in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.pop_top && cmd.push_scan))
		else $error("push and pop together");
	// a cycle result is always the last one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.acyclic |-> out_ch.last)
		else $error("cycle result not last");
	// no input taken while results are pending
	assert property (@(posedge clk) disable iff (!arst_n) out_ch.valid |-> !in_ch.ready)
		else $error("input taken during output");
endmodule
